// File: rtl/core/artq_pkg.sv
// Shared types and constants for the ack/retry transmit queue.
package artq_pkg;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [1:0] STATUS_ACCEPT = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_TICK   = 2'd2;

  localparam logic [2:0] TYPE_MIN = 3'd1;
  localparam logic [2:0] TYPE_MAX = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic        ack;
    logic [2:0]  msg_type;
    logic [31:0] target;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        send_valid;
    logic        send_boost;
    logic        send_ack;
    logic [2:0]  send_type;
    logic [31:0] send_target;
    logic [7:0]  send_a;
    logic [7:0]  send_b;
    logic [7:0]  send_c;
    logic        dropped;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic do_enq;
    logic do_tick_direct;
    logic do_read;
    logic do_exec;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic res_free;
    logic tick_direct;
  } dp_sts_t;

endpackage

// File: rtl/core/artq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module artq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/artq_ctrl.sv
// Controller state machine: sequences enqueue, direct ticks and entry ticks.
module artq_ctrl import artq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     cmd,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = sts.res_free;
        if (in_valid && sts.res_free) begin
          if (cmd == CMD_ENQUEUE) begin
            ctl.do_enq = 1'b1;
          end else if (sts.tick_direct) begin
            ctl.do_tick_direct = 1'b1;
          end else begin
            ctl.do_read = 1'b1;
            state_next  = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        // entry data is out of the RAM now; wait for room in the result register
        if (sts.res_free) begin
          ctl.do_exec = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/artq_dp.sv
// Datapath: counters, try count, entry store and result register.
module artq_dp import artq_pkg::*; #(
  parameter int QUEUE_DEPTH = 20,
  parameter int MAX_TRIES   = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    ctl,
  output dp_sts_t     sts,
  input  logic        ack_required,
  input  logic [2:0]  msg_type,
  input  logic [31:0] dest_id,
  input  logic [7:0]  field_a,
  input  logic [7:0]  field_b,
  input  logic [7:0]  field_c,
  input  logic        ack_seen,
  input  logic        out_ready,
  output logic        out_valid,
  output res_t        res
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TW = $clog2(MAX_TRIES + 1);
  localparam int EW = $bits(entry_t);

  logic [CW-1:0] rd_cnt, rd_cnt_next;
  logic [CW-1:0] wr_cnt, wr_cnt_next;
  // only the entry at the read pointer can have a nonzero try count
  logic [TW-1:0] tries, tries_next;
  logic          ack_q;
  logic          res_valid, res_valid_next;
  res_t          res_next;
  logic          load;
  logic          full;
  entry_t        wr_entry;
  logic [EW-1:0] rd_raw;
  entry_t        rd_entry;
  logic          type_ok;

  assign full = (wr_cnt == CW'(QUEUE_DEPTH));
  assign sts.tick_direct = (wr_cnt <= rd_cnt) || (rd_cnt >= CW'(QUEUE_DEPTH));
  assign sts.res_free    = !res_valid || out_ready;

  assign wr_entry.ack      = ack_required;
  assign wr_entry.msg_type = msg_type;
  assign wr_entry.target   = dest_id;
  assign wr_entry.a        = field_a;
  assign wr_entry.b        = field_b;
  assign wr_entry.c        = field_c;

  artq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.do_enq && !full),
    .waddr (wr_cnt[AW-1:0]),
    .wdata (wr_entry),
    .re    (ctl.do_read),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);
  assign type_ok  = (rd_entry.msg_type >= TYPE_MIN) && (rd_entry.msg_type <= TYPE_MAX);

  always_comb begin
    rd_cnt_next = rd_cnt;
    wr_cnt_next = wr_cnt;
    tries_next  = tries;
    res_next    = '0;
    load        = 1'b0;

    if (ctl.do_enq) begin
      load = 1'b1;
      if (full) begin
        res_next.status = STATUS_FULL;
      end else begin
        res_next.status = STATUS_ACCEPT;
        wr_cnt_next     = wr_cnt + CW'(1);
      end
    end

    if (ctl.do_tick_direct) begin
      load            = 1'b1;
      res_next.status = STATUS_TICK;
      if (rd_cnt == wr_cnt) begin
        rd_cnt_next = '0;
        wr_cnt_next = '0;
      end
    end

    if (ctl.do_exec) begin
      load            = 1'b1;
      res_next.status = STATUS_TICK;
      if (rd_entry.ack) begin
        if (tries == '0) begin
          tries_next          = TW'(1);
          res_next.send_valid = type_ok;
        end else if (ack_q) begin
          tries_next  = '0;
          rd_cnt_next = rd_cnt + CW'(1);
        end else if (tries >= TW'(MAX_TRIES)) begin
          tries_next       = '0;
          rd_cnt_next      = rd_cnt + CW'(1);
          res_next.dropped = 1'b1;
        end else begin
          tries_next          = tries + TW'(1);
          res_next.send_valid = type_ok;
          res_next.send_boost = type_ok;
        end
      end else begin
        rd_cnt_next         = rd_cnt + CW'(1);
        res_next.send_valid = type_ok;
      end
      if (res_next.send_valid) begin
        res_next.send_ack    = rd_entry.ack;
        res_next.send_type   = rd_entry.msg_type;
        res_next.send_target = rd_entry.target;
        res_next.send_a      = rd_entry.a;
        res_next.send_b      = rd_entry.b;
        res_next.send_c      = rd_entry.c;
      end
    end

    if (load) begin
      res_valid_next = 1'b1;
    end else if (out_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      wr_cnt    <= '0;
      tries     <= '0;
      res_valid <= 1'b0;
    end else begin
      rd_cnt    <= rd_cnt_next;
      wr_cnt    <= wr_cnt_next;
      tries     <= tries_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_read) begin
      ack_q <= ack_seen;
    end
    if (load) begin
      res <= res_next;
    end
  end

  assign out_valid = res_valid;

`ifndef SYNTHESIS
  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    wr_cnt <= CW'(QUEUE_DEPTH))
    else $error("write count beyond queue depth");

  a_rd_le_wr: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= wr_cnt)
    else $error("read count passed write count");

  a_tries_bound: assert property (@(posedge clk) disable iff (rst)
    tries <= TW'(MAX_TRIES))
    else $error("try count beyond limit");

  a_drop_no_send: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.dropped |-> !res.send_valid)
    else $error("dropped beat also requests a send");

  a_drain_clean: assert property (@(posedge clk) disable iff (rst)
    ctl.do_tick_direct && (rd_cnt == wr_cnt) |=> (rd_cnt == '0) && (tries == '0))
    else $error("drain left state behind");
`endif

endmodule

// File: rtl/core/ack_retry_transmit_queue.sv
// Enqueue and ticks that find no entry give their result beat in the cycle after accept.
// A tick that works an entry gives its result after a registered read of the entry store and
//   the retry decision; no new command is taken until that decision is made.
// Throughput: one beat per cycle for enqueues and empty ticks unless the output stalls.
// Reset clears the counters, the try count and the result valid flag; the entry store is
//   not cleared and needs no clearing pass.
module ack_retry_transmit_queue import artq_pkg::*; #(
  parameter int QUEUE_DEPTH = 20,
  parameter int MAX_TRIES   = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic        ack_required,
  input  logic [2:0]  msg_type,
  input  logic [31:0] dest_id,
  input  logic [7:0]  field_a,
  input  logic [7:0]  field_b,
  input  logic [7:0]  field_c,
  input  logic        ack_seen,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        send_valid,
  output logic        send_boost,
  output logic        send_ack,
  output logic [2:0]  send_type,
  output logic [31:0] send_target,
  output logic [7:0]  send_a,
  output logic [7:0]  send_b,
  output logic [7:0]  send_c,
  output logic        dropped
);

  ctl_cmd_t ctl;
  dp_sts_t  sts;
  res_t     res;

  artq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  artq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_TRIES   (MAX_TRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .ack_required (ack_required),
    .msg_type     (msg_type),
    .dest_id      (dest_id),
    .field_a      (field_a),
    .field_b      (field_b),
    .field_c      (field_c),
    .ack_seen     (ack_seen),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .res          (res)
  );

  assign status      = res.status;
  assign send_valid  = res.send_valid;
  assign send_boost  = res.send_boost;
  assign send_ack    = res.send_ack;
  assign send_type   = res.send_type;
  assign send_target = res.send_target;
  assign send_a      = res.send_a;
  assign send_b      = res.send_b;
  assign send_c      = res.send_c;
  assign dropped     = res.dropped;

endmodule
